[design/rac_pkg.sv]
package rac_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int BLOCK_SIZE_DEF = 32;
    localparam int VAL_W          = 48;
    localparam int OPND_W         = 64;
    localparam int CNT_W          = 11;
    localparam int IDX_W          = 10;
    localparam int RECIP_SH       = 32;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_COUNT = 2'd1;
    localparam logic [1:0] REQ_LOAD  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SETUP2,
        ST_SCAN,
        ST_DONE
    } state_t;

    // clamp operand to +-2^48
    function automatic logic signed [49:0] clamp_opnd(input logic signed [63:0] v);
        logic signed [63:0] lim;
        lim = 64'sd1 <<< 48;
        if (v > lim) begin
            clamp_opnd = 50'sd1 <<< 48;
        end else if (v < -lim) begin
            clamp_opnd = -(50'sd1 <<< 48);
        end else begin
            clamp_opnd = 50'(v);
        end
    endfunction

    // saturate to 48-bit signed
    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        if (v > 51'sh0_7FFF_FFFF_FFFF) begin
            sat48 = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -51'sh0_8000_0000_0000) begin
            sat48 = 48'sh8000_0000_0000;
        end else begin
            sat48 = 48'(v);
        end
    endfunction

endpackage

[design/range_add_count_below.sv]
// sequence: a load passes SETUP and SETUP2, which writes the element; an add or count
//   passes SETUP, SETUP2, SCAN and DONE; SCAN reads elements through the element memory
//   read-modify-write port (edge blocks of an add, every element in range for a count)
//   and updates the tag of each interior block of an add; DONE registers a count result
// an empty count goes straight to DONE; an empty add or an unknown request stays in IDLE
// throughput: one request at a time, the next request accepted once back in IDLE
// reset: synchronous active-low aresetn clears control, block tags to zero and
//   element_count to CAPACITY; element memory is undefined until loaded
module range_add_count_below #(
    parameter int CAPACITY   = rac_pkg::CAPACITY_DEF,
    parameter int BLOCK_SIZE = rac_pkg::BLOCK_SIZE_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic [rac_pkg::IDX_W-1:0]         s_left,
    input  logic [rac_pkg::IDX_W-1:0]         s_right,
    input  logic signed [rac_pkg::OPND_W-1:0] s_operand,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rac_pkg::CNT_W-1:0]         m_below_count,
    // element_count register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rac_pkg::CNT_W-1:0]         cfg_data
);

    localparam int NBLK  = (CAPACITY + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int AW    = $clog2(CAPACITY);
    localparam int IW    = $clog2(CAPACITY + 2 * BLOCK_SIZE) + 1;
    localparam int BW    = (NBLK > 1) ? $clog2(NBLK) : 1;
    localparam int WW    = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
    localparam int EW    = $clog2(CAPACITY + 1) + 1;
    localparam logic [63:0] RECIP =
        64'(((64'd1 << rac_pkg::RECIP_SH) + 64'(BLOCK_SIZE) - 64'd1) / 64'(BLOCK_SIZE));

    rac_pkg::state_t state_reg, state_next;

    // request fields held during the scan
    logic [1:0]                   type_reg, type_next;
    logic [IW-1:0]                l_reg, l_next;
    logic [IW-1:0]                r_reg, r_next;
    logic signed [63:0]           k_reg, k_next;
    logic [BW:0]                  p_reg, p_next;   // first edge block
    logic [BW:0]                  q_reg, q_next;   // last edge block

    // scan position
    logic [IW-1:0]                i_reg, i_next;
    logic [BW:0]                  b_reg, b_next;
    logic [WW-1:0]                w_reg, w_next;

    // read stage
    logic                         v1_reg, v1_next;
    logic [AW-1:0]                a1_reg, a1_next;
    logic [BW:0]                  b1_reg, b1_next;

    logic [EW-1:0]                cnt_reg, cnt_next;
    logic [EW-1:0]                ec_reg, ec_next;
    logic                         mv_reg, mv_next;
    logic [rac_pkg::CNT_W-1:0]    mc_reg, mc_next;

    logic signed [47:0]           off_reg [NBLK];
    logic                         off_we;
    logic [BW-1:0]                off_wa;
    logic signed [47:0]           off_wd;

    logic                         rd_en, wr_en;
    logic [AW-1:0]                rd_addr, wr_addr;
    logic signed [47:0]           rd_data, wr_data;

    logic signed [49:0]           kc;
    logic [IW-1:0]                s_l, s_r, r_eff;
    logic                         empty;
    logic [IW+33:0]               prod_l, prod_r;
    logic [IW+BW+9:0]             pbs;
    logic signed [48:0]           eff;
    logic signed [47:0]           off_b1, off_p, off_b;
    logic [EW-1:0]                ec_w;

    assign kc = rac_pkg::clamp_opnd(k_reg);

    // effective range end
    assign s_l   = IW'(s_left);
    assign s_r   = IW'(s_right);
    assign r_eff = (s_r >= IW'(ec_reg)) ? IW'(ec_reg - EW'(1)) : s_r;
    assign empty = (s_l >= IW'(ec_reg)) || (s_l > r_eff);

    // block number by reciprocal multiply
    assign prod_l = (IW+34)'(l_reg) * (IW+34)'(RECIP[32:0]);
    assign prod_r = (IW+34)'(r_reg) * (IW+34)'(RECIP[32:0]);
    assign pbs    = (IW+BW+10)'(p_reg) * (IW+BW+10)'(BLOCK_SIZE);

    assign off_b1 = off_reg[b1_reg[BW-1:0]];
    assign off_p  = off_reg[p_reg[BW-1:0]];
    assign off_b  = off_reg[b_reg[BW-1:0]];
    assign eff    = 49'(rd_data) + 49'(off_b1);

    // config clamp: zero acts as one, beyond capacity acts as capacity
    always_comb begin
        ec_w = EW'(cfg_data);
        if (cfg_data == '0) begin
            ec_w = EW'(1);
        end else if (EW'(cfg_data) > EW'(CAPACITY)) begin
            ec_w = EW'(CAPACITY);
        end
    end

    rac_elem_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb begin
        state_next = state_reg;
        type_next  = type_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        i_next     = i_reg;
        b_next     = b_reg;
        w_next     = w_reg;
        v1_next    = 1'b0;
        a1_next    = a1_reg;
        b1_next    = b1_reg;
        cnt_next   = cnt_reg;
        ec_next    = ec_reg;
        mv_next    = mv_reg;
        mc_next    = mc_reg;
        off_we     = 1'b0;
        off_wa     = b_reg[BW-1:0];
        off_wd     = rac_pkg::sat48(51'(off_b) + 51'(kc));
        rd_en      = 1'b0;
        rd_addr    = i_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = a1_reg;
        wr_data    = rac_pkg::sat48(51'(rd_data) + 51'(kc));
        s_ready    = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        if (cfg_valid) begin
            ec_next = ec_w;
        end

        // element read-modify-write stage
        if (v1_reg) begin
            if (type_reg == rac_pkg::REQ_ADD) begin
                wr_en = 1'b1;
            end else if ($signed({{15{eff[48]}}, eff}) < k_reg) begin
                cnt_next = cnt_reg + EW'(1);
            end
        end

        case (state_reg)
            rac_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    type_next = s_req_type;
                    l_next    = s_l;
                    r_next    = r_eff;
                    k_next    = s_operand;
                    cnt_next  = '0;
                    case (s_req_type)
                        rac_pkg::REQ_LOAD: begin
                            if (s_l < IW'(ec_reg)) begin
                                state_next = rac_pkg::ST_SETUP;
                            end
                        end
                        rac_pkg::REQ_ADD: begin
                            if (!empty) begin
                                state_next = rac_pkg::ST_SETUP;
                            end
                        end
                        rac_pkg::REQ_COUNT: begin
                            state_next = empty ? rac_pkg::ST_DONE : rac_pkg::ST_SETUP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rac_pkg::ST_SETUP: begin
                p_next     = (BW+1)'(prod_l >> rac_pkg::RECIP_SH);
                q_next     = (BW+1)'(prod_r >> rac_pkg::RECIP_SH);
                state_next = rac_pkg::ST_SETUP2;
            end
            rac_pkg::ST_SETUP2: begin
                b_next = p_reg;
                i_next = l_reg;
                w_next = WW'(l_reg - IW'(pbs));
                if (type_reg == rac_pkg::REQ_LOAD) begin
                    wr_en      = 1'b1;
                    wr_addr    = l_reg[AW-1:0];
                    wr_data    = rac_pkg::sat48(51'(rac_pkg::sat48(51'(kc))) - 51'(off_p));
                    state_next = rac_pkg::ST_IDLE;
                end else begin
                    state_next = rac_pkg::ST_SCAN;
                end
            end
            rac_pkg::ST_SCAN: begin
                if (i_reg > r_reg) begin
                    state_next = rac_pkg::ST_DONE;
                end else if (type_reg == rac_pkg::REQ_ADD && b_reg != p_reg && b_reg != q_reg) begin
                    off_we = 1'b1;
                    i_next = i_reg + IW'(BLOCK_SIZE);
                    b_next = b_reg + (BW+1)'(1);
                end else begin
                    rd_en   = 1'b1;
                    v1_next = 1'b1;
                    a1_next = i_reg[AW-1:0];
                    b1_next = b_reg;
                    i_next  = i_reg + IW'(1);
                    if (32'(w_reg) == BLOCK_SIZE - 1) begin
                        w_next = '0;
                        b_next = b_reg + (BW+1)'(1);
                    end else begin
                        w_next = w_reg + WW'(1);
                    end
                end
            end
            rac_pkg::ST_DONE: begin
                if (type_reg != rac_pkg::REQ_COUNT) begin
                    state_next = rac_pkg::ST_IDLE;
                end else if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mc_next    = rac_pkg::CNT_W'(cnt_reg);
                    state_next = rac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rac_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rac_pkg::ST_IDLE;
            v1_reg    <= 1'b0;
            mv_reg    <= 1'b0;
            ec_reg    <= EW'(CAPACITY);
            for (int n = 0; n < NBLK; n++) begin
                off_reg[n] <= '0;
            end
        end else begin
            state_reg <= state_next;
            v1_reg    <= v1_next;
            mv_reg    <= mv_next;
            ec_reg    <= ec_next;
            if (off_we) begin
                off_reg[off_wa] <= off_wd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        type_reg <= type_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        i_reg    <= i_next;
        b_reg    <= b_next;
        w_reg    <= w_next;
        a1_reg   <= a1_next;
        b1_reg   <= b1_next;
        cnt_reg  <= cnt_next;
        mc_reg   <= mc_next;
    end

    assign m_valid       = mv_reg;
    assign m_below_count = mc_reg;
    assign cfg_ready     = 1'b1;

endmodule

[design/rac_elem_mem.sv]
module rac_elem_mem #(
    parameter int DEPTH = rac_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic signed [rac_pkg::VAL_W-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic signed [rac_pkg::VAL_W-1:0] wr_data
);

    logic signed [rac_pkg::VAL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/rac_checker.sv]
module rac_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [1:0]                s_req_type,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [rac_pkg::CNT_W-1:0] m_below_count,
    input logic                      cfg_ready
);

    // result beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_below_count))
        else $error("result beat changed while stalled");

    // no result right out of reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // ready drops in the cycle after a count beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_req_type == rac_pkg::REQ_COUNT |=> !s_ready)
        else $error("ready right after count beat");

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_below_count <= 11'd1024)
        else $error("count beyond capacity");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("config port not ready");

endmodule

bind range_add_count_below rac_checker u_rac_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_req_type    (s_req_type),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_below_count (m_below_count),
    .cfg_ready     (cfg_ready)
);

[test/range_add_count_below_test.sv]
module range_add_count_below_test;

    // request code the block must drop without a result
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int NBLK = rac_pkg::CAPACITY_DEF / rac_pkg::BLOCK_SIZE_DEF;
    // cycles to let a result-less request finish before touching the register
    localparam int SETTLE = 200;
    // element count of the first store, four blocks
    localparam int STORE_INIT = 128;

    typedef struct {
        logic [1:0]                        kind;
        logic [rac_pkg::IDX_W-1:0]         left;
        logic [rac_pkg::IDX_W-1:0]         right;
        logic signed [rac_pkg::OPND_W-1:0] operand;
    } rac_req_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [rac_pkg::IDX_W-1:0] s_left = '0;
    logic [rac_pkg::IDX_W-1:0] s_right = '0;
    logic signed [rac_pkg::OPND_W-1:0] s_operand = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [rac_pkg::CNT_W-1:0] m_below_count;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rac_pkg::CNT_W-1:0] cfg_data = '0;

    range_add_count_below uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_left        (s_left),
        .s_right       (s_right),
        .s_operand     (s_operand),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_below_count (m_below_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // requests waiting for the driver, and counts the block still owes us
    rac_req_t pending_reqs[$];
    logic [rac_pkg::CNT_W-1:0] count_due[$];
    int errors = 0;

    // shadow copy of the store: raw element values and per-block add tags
    longint elem_val[rac_pkg::CAPACITY_DEF];
    longint blk_tag[NBLK];
    int in_use = rac_pkg::CAPACITY_DEF;   // element count as the block sees it
    int gen_count = rac_pkg::CAPACITY_DEF; // element count the generator aims at

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
        errors++;
    endtask

    // register value to the element count it really means
    function automatic int count_in_use(input logic [rac_pkg::CNT_W-1:0] v);
        if (v == 0) begin
            return 1;
        end
        return (v > rac_pkg::CAPACITY_DEF) ? rac_pkg::CAPACITY_DEF : int'(v);
    endfunction

    function automatic longint clamp_amount(input longint v);
        longint lim;
        lim = longint'(1) <<< 48;
        if (v > lim) begin
            return lim;
        end
        return (v < -lim) ? -lim : v;
    endfunction

    function automatic longint sat_value(input longint v);
        longint hi;
        hi = (longint'(1) <<< 47) - 1;
        if (v > hi) begin
            return hi;
        end
        return (v < -hi - 1) ? -hi - 1 : v;
    endfunction

    // update the shadow store for one accepted beat, queue a count if one is due
    task automatic predict_request(input rac_req_t rq);
        int lo, hi, pb, qb, cnt;
        longint amt;
        lo = rq.left;
        hi = rq.right;
        cnt = 0;
        if (rq.kind == rac_pkg::REQ_LOAD) begin
            if (lo < in_use) begin
                elem_val[lo] = sat_value(sat_value(clamp_amount(rq.operand))
                                         - blk_tag[lo / rac_pkg::BLOCK_SIZE_DEF]);
            end
        end else if (rq.kind == rac_pkg::REQ_ADD || rq.kind == rac_pkg::REQ_COUNT) begin
            if (hi >= in_use) begin
                hi = in_use - 1;
            end
            pb = lo / rac_pkg::BLOCK_SIZE_DEF;
            qb = hi / rac_pkg::BLOCK_SIZE_DEF;
            if (rq.kind == rac_pkg::REQ_ADD && lo < in_use && lo <= hi) begin
                amt = clamp_amount(rq.operand);
                // edge blocks element by element, interior ones through the tag
                for (int i = lo; i <= hi; i++) begin
                    if (i / rac_pkg::BLOCK_SIZE_DEF == pb || i / rac_pkg::BLOCK_SIZE_DEF == qb) begin
                        elem_val[i] = sat_value(elem_val[i] + amt);
                    end
                end
                for (int b = pb + 1; b < qb; b++) begin
                    blk_tag[b] = sat_value(blk_tag[b] + amt);
                end
            end else if (rq.kind == rac_pkg::REQ_COUNT) begin
                if (lo < in_use) begin
                    for (int i = lo; i <= hi; i++) begin
                        if (elem_val[i] + blk_tag[i / rac_pkg::BLOCK_SIZE_DEF] < rq.operand) begin
                            cnt++;
                        end
                    end
                end
                count_due.push_back(rac_pkg::CNT_W'(cnt));
            end
        end
    endtask

    // monitor: everything sampled at the rising edge
    logic s_taken = 1'b0;
    logic [rac_pkg::CNT_W-1:0] want_count;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= s_valid && s_ready;
            if (cfg_valid && cfg_ready) begin
                in_use = count_in_use(cfg_data);
            end
            if (s_valid && s_ready) begin
                predict_request('{s_req_type, s_left, s_right, s_operand});
            end
            if (m_valid && m_ready) begin
                if (count_due.size() == 0) begin
                    report_mismatch("unexpected result beat, below_count", m_below_count, 0);
                end else begin
                    want_count = count_due.pop_front();
                    if (m_below_count !== want_count) begin
                        report_mismatch("below_count", m_below_count, want_count);
                    end
                end
            end
        end
    end

    // driver: bursts of beats with random gaps, updated at the falling edge
    int burst_left = 0;
    int gap_left = 0;
    rac_req_t next_req;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                next_req = pending_reqs.pop_front();
                s_req_type <= next_req.kind;
                s_left <= next_req.left;
                s_right <= next_req.right;
                s_operand <= next_req.operand;
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // new burst; roughly a third follow on back to back
                    burst_left = $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern switches mode now and then; a kick forces a long hold
    int hold_kick = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = 400;
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 150);
            end
            rx_mode_left--;
            case (rx_mode)
                0: begin
                    m_ready <= 1'b1;
                end
                1: begin
                    m_ready <= $urandom_range(0, 1);
                end
                default: begin
                    m_ready <= ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    task automatic push_req(input logic [1:0] kind, input int lo, input int hi,
                            input longint val);
        pending_reqs.push_back('{kind, rac_pkg::IDX_W'(lo), rac_pkg::IDX_W'(hi), val});
    endtask

    // mostly small numbers, sometimes extremes and raw 64-bit patterns
    function automatic longint pick_value(input int small_span);
        case ($urandom_range(0, 19))
            0: return {$urandom, $urandom};
            1: return longint'(1) <<< 62;
            2: return longint'(64'h8000_0000_0000_0000);
            3: return ($urandom_range(0, 1) ? 1 : -1) * ((longint'(1) <<< 48)
                      + $urandom_range(0, 2) - 1);
            default: return longint'($urandom_range(0, 2 * small_span)) - small_span;
        endcase
    endfunction

    // stop feeding until the block owes nothing and has gone quiet
    task automatic drain();
        while (pending_reqs.size() > 0 || count_due.size() > 0 || s_valid) begin
            @(posedge aclk);
        end
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_count(input logic [rac_pkg::CNT_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do begin
            @(posedge aclk);
        end while (!(cfg_valid && cfg_ready));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_count = count_in_use(v);
    endtask

    task automatic reload_store();
        for (int i = 0; i < gen_count; i++) begin
            push_req(rac_pkg::REQ_LOAD, i, $urandom_range(0, 1023), pick_value(1000));
        end
    endtask

    // random mix; ranges mostly short so scans stay quick
    task automatic random_phase(input int n);
        int lo, hi, pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, gen_count - 1);
            case ($urandom_range(0, 9))
                0: hi = 1023;
                1, 2: hi = lo + $urandom_range(0, 200);
                3: hi = $urandom_range(0, 1023);
                default: hi = lo + $urandom_range(0, 40);
            endcase
            if (hi > 1023) begin
                hi = 1023;
            end
            if (pick < 40) begin
                push_req(rac_pkg::REQ_COUNT, lo, hi, ($urandom_range(0, 6) == 0)
                         ? pick_value(1100) : longint'($urandom_range(0, 2400)) - 1200);
            end else if (pick < 75) begin
                push_req(rac_pkg::REQ_ADD, lo, hi, ($urandom_range(0, 6) == 0)
                         ? pick_value(50) : longint'($urandom_range(0, 100)) - 50);
            end else if (pick < 95) begin
                push_req(rac_pkg::REQ_LOAD, lo, hi, ($urandom_range(0, 19) == 0)
                         ? pick_value(1000) : longint'($urandom_range(0, 2000)) - 1000);
            end else begin
                push_req(REQ_NONE, lo, hi, pick_value(1000));
            end
        end
    endtask

    int phase_counts[6] = '{0, 160, 1, 37, 200, 0};

    initial begin
        for (int i = 0; i < rac_pkg::CAPACITY_DEF; i++) begin
            elem_val[i] = 0;
        end
        for (int b = 0; b < NBLK; b++) begin
            blk_tag[b] = 0;
        end
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (SETTLE) @(posedge aclk);

        // small store, every element loaded before anything reads it
        write_count(rac_pkg::CNT_W'(STORE_INIT));
        reload_store();

        // directed: range shapes, empty ranges, extremes of every field
        push_req(rac_pkg::REQ_COUNT, 0, 1023, 0);
        push_req(rac_pkg::REQ_COUNT, 0, 1023, 64'sh7FFF_FFFF_FFFF_FFFF);
        push_req(rac_pkg::REQ_COUNT, 0, 1023, 64'sh8000_0000_0000_0000);
        push_req(rac_pkg::REQ_COUNT, 5, 5, 1);
        push_req(rac_pkg::REQ_COUNT, 10, 3, 500);       // left past right
        push_req(rac_pkg::REQ_COUNT, 1023, 1023, 2000); // left past the end
        push_req(rac_pkg::REQ_COUNT, 3, 40, 0);         // edge blocks next to each other, nothing between
        push_req(rac_pkg::REQ_ADD, 5, 1000, 7);         // interior blocks take the tag
        push_req(rac_pkg::REQ_ADD, 40, 50, -3);         // inside a single block
        push_req(rac_pkg::REQ_ADD, 200, 100, 9);        // empty, no effect
        push_req(rac_pkg::REQ_ADD, 0, 1023, -1);
        push_req(rac_pkg::REQ_COUNT, 17, 900, 3);
        push_req(rac_pkg::REQ_LOAD, 7, 0, 64'sh4000_0000_0000_0000);  // clamp then saturate
        push_req(rac_pkg::REQ_LOAD, 8, 1023, 64'sh8000_0000_0000_0000);
        push_req(rac_pkg::REQ_LOAD, 9, 0, 64'sh0000_8000_0000_0000);
        push_req(REQ_NONE, 1023, 1023, -1);
        push_req(rac_pkg::REQ_COUNT, 0, 63, 0);
        push_req(rac_pkg::REQ_ADD, 33, 990, 64'sh4000_0000_0000_0000); // interior tag saturates high
        push_req(rac_pkg::REQ_COUNT, 0, 1023, 64'sh0000_7FFF_FFFF_FFFF);
        push_req(rac_pkg::REQ_ADD, 33, 990, 64'sh8000_0000_0000_0000); // and low
        push_req(rac_pkg::REQ_ADD, 64, 127, 64'sh0001_0000_0000_0000);
        push_req(rac_pkg::REQ_COUNT, 0, 1023, 64'shFFFF_8000_0000_0001);
        push_req(rac_pkg::REQ_COUNT, 30, 1023, 0);
        drain();

        // fresh values, then random traffic
        reload_store();
        random_phase(40);
        drain();

        phase_counts[5] = $urandom_range(2, 128);
        for (int p = 0; p < 6; p++) begin
            write_count(rac_pkg::CNT_W'(phase_counts[p]));
            reload_store();
            random_phase(30);
            // hold results off for a long stretch while requests keep coming
            if (p == 4) begin
                hold_kick++;
            end
            drain();
        end

        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
